@@ rtl/tle_pkg.sv @@
// ----------------------------------------------------------------------------
// tle_pkg - shared types and constants for the terminal line editor
// Line capacity, key codes, output kinds and the fixed echo strings.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int LINE_CAP = 32;
  localparam int IDX_W    = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;

  typedef logic [IDX_W-1:0] idx_t;

  // output word kinds
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  // key codes
  localparam logic [7:0] KEY_ETX      = 8'h03;
  localparam logic [7:0] KEY_BS       = 8'h08;
  localparam logic [7:0] KEY_LF       = 8'h0A;
  localparam logic [7:0] KEY_CR       = 8'h0D;
  localparam logic [7:0] KEY_ESC      = 8'h1B;
  localparam logic [7:0] KEY_SPACE    = 8'h20;
  localparam logic [7:0] KEY_RIGHT    = 8'h43;  // 'C'
  localparam logic [7:0] KEY_LEFT     = 8'h44;  // 'D'
  localparam logic [7:0] KEY_LBRACKET = 8'h5B;
  localparam logic [7:0] KEY_CARET    = 8'h5E;
  localparam logic [7:0] KEY_TILDE    = 8'h7E;
  localparam logic [7:0] KEY_DEL      = 8'h7F;

  // fixed echo strings
  typedef logic [1:0] str_sel_t;
  typedef logic [3:0] str_idx_t;

  localparam str_sel_t STR_CRLF   = 2'd0;  // CR LF
  localparam str_sel_t STR_PROMPT = 2'd1;  // "CLI> "
  localparam str_sel_t STR_CTRLC  = 2'd2;  // "^C" CR LF "CLI> "
  localparam str_sel_t STR_SPBS   = 2'd3;  // space, BS

  function automatic str_idx_t str_last_idx(str_sel_t sel);
    str_idx_t r;
    case (sel)
      STR_CRLF:   r = 4'd1;
      STR_PROMPT: r = 4'd4;
      STR_CTRLC:  r = 4'd8;
      STR_SPBS:   r = 4'd1;
      default:    r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] prompt_char(logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd0:    r = 8'h43;  // C
      3'd1:    r = 8'h4C;  // L
      3'd2:    r = 8'h49;  // I
      3'd3:    r = 8'h3E;  // >
      default: r = KEY_SPACE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] str_char(str_sel_t sel, str_idx_t idx);
    logic [7:0] r;
    case (sel)
      STR_CRLF:   r = (idx == 4'd0) ? KEY_CR : KEY_LF;
      STR_PROMPT: r = prompt_char(idx[2:0]);
      STR_CTRLC: begin
        case (idx)
          4'd0:    r = KEY_CARET;
          4'd1:    r = 8'h43;
          4'd2:    r = KEY_CR;
          4'd3:    r = KEY_LF;
          default: r = prompt_char(3'(idx - 4'd4));
        endcase
      end
      STR_SPBS:   r = (idx == 4'd0) ? KEY_SPACE : KEY_BS;
      default:    r = KEY_SPACE;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/terminal_line_editor.sv @@
// ----------------------------------------------------------------------------
// terminal_line_editor - line editor for a serial terminal
// Takes one key byte at a time, edits a line store and emits echo words,
// committed line bytes and interrupt events.
// ----------------------------------------------------------------------------
// Order of work: a right arrow reads the store before its first output word;
//   insert/delete first shift the line store one entry at a time (ST_SH_RD
//   reads an entry, ST_SH_WR writes it one place over).
// One key at a time: s_tready is high only in ST_IDLE, so a new key waits
//   until the last key's shift steps, byte write, store reads and output
//   words are issued; the line store (registered read) and the shared emit
//   path serialise this work.
// Reset: rst (sync, high) clears line length, cursor, escape state and the
//   interrupt enable; the line store itself is not cleared.
module terminal_line_editor (
  input  logic       clk,
  input  logic       rst,
  // key input
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] key_byte
  // editor output
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] data_byte
  output logic [1:0] m_tuser,    // [1:0] kind
  output logic       m_tlast,    // last word caused by this key
  // config
  input  logic       cfg_we,
  input  logic       cfg_wdata   // interrupt_enable
);

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_SH_RD  = 4'd2;  // shift: read one entry
  localparam logic [3:0] ST_SH_WR  = 4'd3;  // shift: write it one place over
  localparam logic [3:0] ST_INS_WR = 4'd4;  // write the inserted byte
  localparam logic [3:0] ST_CHAR   = 4'd5;  // emit one held word
  localparam logic [3:0] ST_STR    = 4'd6;  // emit a fixed string
  localparam logic [3:0] ST_RD     = 4'd7;  // read store for tail/commit
  localparam logic [3:0] ST_EMIT   = 4'd8;  // emit store byte
  localparam logic [3:0] ST_BSN    = 4'd9;  // emit cnt backspaces

  // key operations
  localparam logic [2:0] OP_LEFT  = 3'd0;
  localparam logic [2:0] OP_RIGHT = 3'd1;
  localparam logic [2:0] OP_ENTER = 3'd2;
  localparam logic [2:0] OP_ETX   = 3'd3;
  localparam logic [2:0] OP_INS   = 3'd4;
  localparam logic [2:0] OP_DEL   = 3'd5;

  // escape decoder
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  logic [3:0] state;
  logic [2:0] op;
  logic [7:0] key;
  logic [1:0] esc;
  logic       irq_en;

  tle_pkg::idx_t len;     // line length
  tle_pkg::idx_t cur;     // cursor
  tle_pkg::idx_t i;       // walk index
  tle_pkg::idx_t stop;    // end of a store read run
  tle_pkg::idx_t cnt;     // backspaces left

  logic [1:0] rd_kind;
  logic [7:0] ch_data;
  logic [1:0] ch_kind;
  logic       ch_last;

  tle_pkg::str_sel_t str_sel;
  tle_pkg::str_idx_t str_idx;
  logic              str_last;

  // line store port
  logic          ram_we;
  tle_pkg::idx_t ram_waddr;
  logic [6:0]    ram_wdata;
  logic          ram_re;
  tle_pkg::idx_t ram_raddr;
  logic [6:0]    ram_rdata;

  // shared emit path
  logic       can_emit;
  logic       emit_go;
  logic [1:0] emit_kind;
  logic [7:0] emit_data;
  logic       emit_last;

  tle_ram #(
    .WIDTH (7),
    .DEPTH (tle_pkg::LINE_CAP)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign can_emit = !m_tvalid || m_tready;

  always_comb begin
    emit_go   = 1'b0;
    emit_kind = tle_pkg::KIND_ECHO;
    emit_data = tle_pkg::KEY_BS;
    emit_last = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = i;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = i;
    case (state)
      ST_CHAR: begin
        emit_go   = can_emit;
        emit_kind = ch_kind;
        emit_data = ch_data;
        emit_last = ch_last;
      end
      ST_STR: begin
        emit_go   = can_emit;
        emit_data = tle_pkg::str_char(str_sel, str_idx);
        emit_last = str_last && (str_idx == tle_pkg::str_last_idx(str_sel));
      end
      ST_EMIT: begin
        emit_go   = can_emit;
        emit_kind = rd_kind;
        emit_data = {1'b0, ram_rdata};
        emit_last = (op == OP_RIGHT);
      end
      ST_BSN: begin
        emit_go   = can_emit;
        emit_last = (cnt == tle_pkg::idx_t'(1));
      end
      ST_SH_RD: begin
        // insert walks down from the end, delete walks up from the cursor
        if (op == OP_INS) begin
          ram_re    = (i != cur);
          ram_raddr = i - tle_pkg::idx_t'(1);
        end else begin
          ram_re    = (i != len);
          ram_raddr = i;
        end
      end
      ST_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = (op == OP_INS) ? i : i - tle_pkg::idx_t'(1);
      end
      ST_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cur;
        ram_wdata = key[6:0];
      end
      ST_RD: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit_go) begin
      m_tdata <= emit_data;
      m_tuser <= emit_kind;
      m_tlast <= emit_last;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      esc    <= ESC_NONE;
      len    <= '0;
      cur    <= '0;
      irq_en <= 1'b0;
    end else begin
      if (cfg_we) begin
        irq_en <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            key   <= s_tdata;
            state <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          state <= ST_IDLE;
          case (esc)
            ESC_CSI: begin
              esc <= ESC_NONE;
              if (key == tle_pkg::KEY_LEFT && cur != '0) begin
                op      <= OP_LEFT;
                cur     <= cur - tle_pkg::idx_t'(1);
                ch_kind <= tle_pkg::KIND_ECHO;
                ch_data <= tle_pkg::KEY_BS;
                ch_last <= 1'b1;
                state   <= ST_CHAR;
              end else if (key == tle_pkg::KEY_RIGHT && cur < len) begin
                op      <= OP_RIGHT;
                i       <= cur;
                stop    <= cur + tle_pkg::idx_t'(1);
                cur     <= cur + tle_pkg::idx_t'(1);
                rd_kind <= tle_pkg::KIND_ECHO;
                state   <= ST_RD;
              end
            end
            ESC_SEEN: begin
              esc <= (key == tle_pkg::KEY_LBRACKET) ? ESC_CSI : ESC_NONE;
            end
            default: begin
              if (key == tle_pkg::KEY_ESC) begin
                esc <= ESC_SEEN;
              end else if (key == tle_pkg::KEY_CR) begin
                op       <= OP_ENTER;
                stop     <= len;
                len      <= '0;
                cur      <= '0;
                str_sel  <= tle_pkg::STR_CRLF;
                str_idx  <= '0;
                str_last <= 1'b0;
                state    <= ST_STR;
              end else if (key == tle_pkg::KEY_ETX) begin
                op  <= OP_ETX;
                len <= '0;
                cur <= '0;
                if (irq_en) begin
                  ch_kind <= tle_pkg::KIND_EVENT;
                  ch_data <= '0;
                  ch_last <= 1'b0;
                  state   <= ST_CHAR;
                end else begin
                  str_sel  <= tle_pkg::STR_CTRLC;
                  str_idx  <= '0;
                  str_last <= 1'b1;
                  state    <= ST_STR;
                end
              end else if (key == tle_pkg::KEY_BS || key == tle_pkg::KEY_DEL) begin
                if (cur != '0) begin
                  op    <= OP_DEL;
                  i     <= cur;
                  state <= ST_SH_RD;
                end
              end else if (key inside {[tle_pkg::KEY_SPACE:tle_pkg::KEY_TILDE]}) begin
                // full line drops the key
                if (len != tle_pkg::idx_t'(tle_pkg::LINE_CAP - 1)) begin
                  op    <= OP_INS;
                  i     <= len;
                  state <= ST_SH_RD;
                end
              end
            end
          endcase
        end

        ST_SH_RD: begin
          if (op == OP_INS) begin
            state <= (i == cur) ? ST_INS_WR : ST_SH_WR;
          end else if (i == len) begin
            len     <= len - tle_pkg::idx_t'(1);
            cur     <= cur - tle_pkg::idx_t'(1);
            ch_kind <= tle_pkg::KIND_ECHO;
            ch_data <= tle_pkg::KEY_BS;
            ch_last <= 1'b0;
            state   <= ST_CHAR;
          end else begin
            state <= ST_SH_WR;
          end
        end

        ST_SH_WR: begin
          i     <= (op == OP_INS) ? i - tle_pkg::idx_t'(1) : i + tle_pkg::idx_t'(1);
          state <= ST_SH_RD;
        end

        ST_INS_WR: begin
          len     <= len + tle_pkg::idx_t'(1);
          cur     <= cur + tle_pkg::idx_t'(1);
          ch_kind <= tle_pkg::KIND_ECHO;
          ch_data <= {1'b0, key[6:0]};
          ch_last <= (cur == len);  // no tail after the new byte
          state   <= ST_CHAR;
        end

        ST_CHAR: begin
          if (emit_go) begin
            state <= ST_IDLE;
            case (op)
              OP_ETX: begin
                str_sel  <= tle_pkg::STR_CTRLC;
                str_idx  <= '0;
                str_last <= 1'b1;
                state    <= ST_STR;
              end
              OP_INS, OP_DEL: begin
                if (cur != len) begin
                  i       <= cur;
                  stop    <= len;
                  rd_kind <= tle_pkg::KIND_ECHO;
                  state   <= ST_RD;
                end else if (op == OP_DEL) begin
                  str_sel  <= tle_pkg::STR_SPBS;
                  str_idx  <= '0;
                  str_last <= 1'b1;
                  state    <= ST_STR;
                end
              end
              default: begin
              end
            endcase
          end
        end

        ST_STR: begin
          if (emit_go) begin
            if (str_idx == tle_pkg::str_last_idx(str_sel)) begin
              state <= ST_IDLE;
              case (str_sel)
                tle_pkg::STR_CRLF: begin
                  str_idx <= '0;
                  if (stop != '0) begin
                    i       <= '0;
                    rd_kind <= tle_pkg::KIND_LINE;
                    state   <= ST_RD;
                  end else begin
                    str_sel  <= tle_pkg::STR_PROMPT;
                    str_last <= 1'b1;
                    state    <= ST_STR;
                  end
                end
                tle_pkg::STR_SPBS: begin
                  if (cur != len) begin
                    cnt   <= len - cur;
                    state <= ST_BSN;
                  end
                end
                default: begin
                end
              endcase
            end else begin
              str_idx <= str_idx + 4'd1;
            end
          end
        end

        ST_RD: begin
          state <= ST_EMIT;
        end

        ST_EMIT: begin
          if (emit_go) begin
            if (i + tle_pkg::idx_t'(1) == stop) begin
              state <= ST_IDLE;
              case (op)
                OP_ENTER: begin
                  str_sel  <= tle_pkg::STR_PROMPT;
                  str_idx  <= '0;
                  str_last <= 1'b1;
                  state    <= ST_STR;
                end
                OP_INS: begin
                  cnt   <= len - cur;
                  state <= ST_BSN;
                end
                OP_DEL: begin
                  str_sel  <= tle_pkg::STR_SPBS;
                  str_idx  <= '0;
                  str_last <= 1'b0;
                  state    <= ST_STR;
                end
                default: begin
                end
              endcase
            end else begin
              i     <= i + tle_pkg::idx_t'(1);
              state <= ST_RD;
            end
          end
        end

        ST_BSN: begin
          if (emit_go) begin
            cnt <= cnt - tle_pkg::idx_t'(1);
            if (cnt == tle_pkg::idx_t'(1)) begin
              state <= ST_IDLE;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/tle_ram.sv @@
// ----------------------------------------------------------------------------
// tle_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/tle_checker.sv @@
// ----------------------------------------------------------------------------
// tle_checker - port-level checks for the terminal line editor
// Watches the key and output channels; bound to the top level.
// ----------------------------------------------------------------------------
module tle_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  // one key at a time: no new key right after one is taken
  a_one_key: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("key taken back to back");

  // no undefined kind code
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == tle_pkg::KIND_ECHO || m_tuser == tle_pkg::KIND_LINE ||
                  m_tuser == tle_pkg::KIND_EVENT))
    else $error("bad output kind");

  // event carries zero data and is followed by the ^C echo
  a_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tle_pkg::KIND_EVENT |-> m_tdata == '0 && !m_tlast)
    else $error("bad interrupt event word");

  // committed line bytes are 7-bit and always followed by the prompt
  a_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == tle_pkg::KIND_LINE |-> !m_tdata[7] && !m_tlast)
    else $error("bad committed line word");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled output word changed");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking bench for terminal_line_editor
// Feeds key bytes on the input stream and checks every output word against a
// shadow editor kept in the bench. A short table of directed keys (escape
// codes, edit keys, ignored bytes) comes first, then random typing sessions
// under several interrupt-enable settings, with random gaps and stalls in all but the quiet one.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT    = 2_000_000;  // cycles before the run is declared hung
  localparam int SETTLE   = 200;        // wait that lets the slowest key finish inside the block
  localparam int MAX_WORDS = 64;        // words one key can cause at most
  localparam int DIR_N    = 24;

  localparam string PROMPT_TEXT = "CLI> ";
  localparam string CTRLC_TEXT  = "^C";

  // escape decoder states of the shadow editor
  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_SEEN = 2'd1,
    ESC_CSI  = 2'd2
  } esc_t;

  // one output word: kind, byte and end-of-key flag
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;

  terminal_line_editor u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow editor: line, length, cursor, escape state and interrupt enable.
  // Entries at or above shadow_len are never read.
  // --------------------------------------------------------------------------
  logic [6:0]    shadow_line [tle_pkg::LINE_CAP];
  tle_pkg::idx_t shadow_len = '0;
  tle_pkg::idx_t shadow_cur = '0;
  esc_t          shadow_esc = ESC_IDLE;
  logic          shadow_irq = 1'b0;

  out_word_t  key_words[$];      // words caused by the key being predicted
  out_word_t  pending_words[$];  // words still owed by the block, oldest first

  int  sent = 0;        // keys sent
  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;    // no gaps and no stalls while set

  function automatic void emit_word(logic [1:0] k, logic [7:0] d);
    // the bench keeps at most MAX_WORDS words per key; extra ones are dropped
    if (key_words.size() < MAX_WORDS)
      key_words.push_back('{kind: k, data: d, last: 1'b0});
  endfunction

  function automatic void emit_prompt();
    int i;
    for (i = 0; i < PROMPT_TEXT.len(); i++)
      emit_word(tle_pkg::KIND_ECHO, PROMPT_TEXT[i]);
  endfunction

  // echo the bytes from the cursor to the end, optionally blank the old last
  // cell, then walk the terminal cursor back to its place
  function automatic void redraw_tail(bit blank);
    int i;
    for (i = shadow_cur; i < shadow_len; i++)
      emit_word(tle_pkg::KIND_ECHO, {1'b0, shadow_line[i]});
    if (blank) begin
      emit_word(tle_pkg::KIND_ECHO, tle_pkg::KEY_SPACE);
      emit_word(tle_pkg::KIND_ECHO, tle_pkg::KEY_BS);
    end
    for (i = shadow_cur; i < shadow_len; i++)
      emit_word(tle_pkg::KIND_ECHO, tle_pkg::KEY_BS);
  endfunction

  // work out the words one key causes and advance the shadow state
  function automatic void edit_key(logic [7:0] key);
    int i;
    key_words.delete();
    case (shadow_esc)
      ESC_CSI: begin
        if (key == tle_pkg::KEY_LEFT) begin
          if (shadow_cur != 0) begin
            emit_word(tle_pkg::KIND_ECHO, tle_pkg::KEY_BS);
            shadow_cur--;
          end
        end else if (key == tle_pkg::KEY_RIGHT) begin
          if (shadow_cur < shadow_len) begin
            emit_word(tle_pkg::KIND_ECHO, {1'b0, shadow_line[shadow_cur]});
            shadow_cur++;
          end
        end
        shadow_esc = ESC_IDLE;  // any other final byte is dropped
      end
      ESC_SEEN: begin
        shadow_esc = (key == tle_pkg::KEY_LBRACKET) ? ESC_CSI : ESC_IDLE;
      end
      default: begin
        if (key == tle_pkg::KEY_ESC) begin
          shadow_esc = ESC_SEEN;
        end else if (key == tle_pkg::KEY_CR) begin
          // commit: CR LF, the line as line words, then a fresh prompt
          emit_word(tle_pkg::KIND_ECHO, tle_pkg::KEY_CR);
          emit_word(tle_pkg::KIND_ECHO, tle_pkg::KEY_LF);
          for (i = 0; i < shadow_len; i++)
            emit_word(tle_pkg::KIND_LINE, {1'b0, shadow_line[i]});
          shadow_len = '0;
          shadow_cur = '0;
          emit_prompt();
        end else if (key == tle_pkg::KEY_ETX) begin
          // abandon: event first when enabled, then ^C CR LF and the prompt
          if (shadow_irq)
            emit_word(tle_pkg::KIND_EVENT, 8'h00);
          shadow_len = '0;
          shadow_cur = '0;
          for (i = 0; i < CTRLC_TEXT.len(); i++)
            emit_word(tle_pkg::KIND_ECHO, CTRLC_TEXT[i]);
          emit_word(tle_pkg::KIND_ECHO, tle_pkg::KEY_CR);
          emit_word(tle_pkg::KIND_ECHO, tle_pkg::KEY_LF);
          emit_prompt();
        end else if (key == tle_pkg::KEY_BS || key == tle_pkg::KEY_DEL) begin
          // delete at line start is silent
          if (shadow_cur != 0) begin
            for (i = shadow_cur; i < shadow_len; i++)
              shadow_line[i-1] = shadow_line[i];
            shadow_len--;
            shadow_cur--;
            emit_word(tle_pkg::KIND_ECHO, tle_pkg::KEY_BS);
            redraw_tail(1'b1);
          end
        end else if (key inside {[tle_pkg::KEY_SPACE:tle_pkg::KEY_TILDE]}) begin
          // a full line takes no more printable bytes, silently
          if (shadow_len < tle_pkg::LINE_CAP - 1) begin
            for (i = shadow_len; i > shadow_cur; i--)
              shadow_line[i] = shadow_line[i-1];
            shadow_line[shadow_cur] = key[6:0];
            shadow_len++;
            emit_word(tle_pkg::KIND_ECHO, {1'b0, shadow_line[shadow_cur]});
            shadow_cur++;
            redraw_tail(1'b0);
          end
        end
        // other control bytes and 128..255 are ignored
      end
    endcase
    if (key_words.size() != 0)
      key_words[key_words.size()-1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then a long one
  // --------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Input side. s_tvalid stays high from one key to the next unless a gap
  // falls between them, so it gets at most one assignment per edge.
  // --------------------------------------------------------------------------
  task automatic drive_key(logic [7:0] key);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // predict, queue the expected words, then send. A typed row replaces the
  // predicted words by a plain echo string (all echo words, last on the end).
  task automatic play_key(logic [7:0] key, bit typed, string echo_text);
    int i;
    edit_key(key);
    if (typed) begin
      for (i = 0; i < echo_text.len(); i++)
        pending_words.push_back('{kind: tle_pkg::KIND_ECHO, data: echo_text[i],
                                  last: (i == echo_text.len() - 1)});
    end else begin
      foreach (key_words[j])
        pending_words.push_back(key_words[j]);
    end
    sent++;
    drive_key(key);
  endtask

  // drop valid, wait for every owed word, then let an ignored key finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_irq_enable(logic en);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_irq = en;
  endtask

  // --------------------------------------------------------------------------
  // Random sessions: mostly typing and cursor moves ending in Enter or
  // Ctrl-C, with some noise bytes and broken escape codes mixed in.
  // Stops once enough keys have been sent.
  // --------------------------------------------------------------------------
  task automatic run_random(int target, bit fill);
    int start;
    int r;
    start = sent;
    // a burst long enough to run the line into its capacity
    if (fill)
      repeat (tle_pkg::LINE_CAP + 2) play_key(8'($urandom_range(32, 126)), 1'b0, "");
    while (sent - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        play_key(8'($urandom_range(32, 126)), 1'b0, "");
      end else if (r < 60) begin
        play_key(tle_pkg::KEY_ESC, 1'b0, "");
        play_key(tle_pkg::KEY_LBRACKET, 1'b0, "");
        play_key($urandom_range(0, 1) ? tle_pkg::KEY_LEFT : tle_pkg::KEY_RIGHT, 1'b0, "");
      end else if (r < 70) begin
        play_key($urandom_range(0, 1) ? tle_pkg::KEY_BS : tle_pkg::KEY_DEL, 1'b0, "");
      end else if (r < 75) begin
        play_key(tle_pkg::KEY_CR, 1'b0, "");
      end else if (r < 79) begin
        play_key(tle_pkg::KEY_ETX, 1'b0, "");
      end else if (r < 87) begin
        play_key(8'($urandom_range(0, 255)), 1'b0, "");
      end else if (r < 93) begin
        // ESC then anything
        play_key(tle_pkg::KEY_ESC, 1'b0, "");
        play_key(8'($urandom_range(0, 255)), 1'b0, "");
      end else begin
        // ESC [ then anything
        play_key(tle_pkg::KEY_ESC, 1'b0, "");
        play_key(tle_pkg::KEY_LBRACKET, 1'b0, "");
        play_key(8'($urandom_range(0, 255)), 1'b0, "");
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready toggles between runs high and stalls of random
  // length; held high in quiet phases.
  // --------------------------------------------------------------------------
  int ready_hold = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_hold <= 0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_tready   <= !m_tready;
      ready_hold <= m_tready ? idle_len() : $urandom_range(0, 6);
    end
  end

  // word check: every accepted word against the oldest owed one
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: kind %0d data %02h last %0d",
                   m_tuser, m_tdata, m_tlast);
      end else begin
        want = pending_words.pop_front();
        if (m_tuser !== want.kind || m_tdata !== want.data || m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: got kind %0d data %02h last %0d, %s %0d data %02h last %0d",
                     m_tuser, m_tdata, m_tlast, "want kind",
                     want.kind, want.data, want.last);
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("** terminal_line_editor: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed keys. Rows marked typed carry their echo text; the rest are
  // left to the shadow editor. Line after row 10: " ~A" with cursor on 'A'.
  // --------------------------------------------------------------------------
  logic [7:0] dir_key   [DIR_N];
  bit         dir_typed [DIR_N];
  string      dir_echo  [DIR_N];

  initial begin
    int n;
    dir_key = '{
      tle_pkg::KEY_CR,                   // Enter on an empty line
      tle_pkg::KEY_BS, tle_pkg::KEY_DEL, // delete at line start
      8'h00, 8'hFF,                      // ignored extremes
      tle_pkg::KEY_SPACE, tle_pkg::KEY_TILDE, "A",  // printable extremes, a letter
      tle_pkg::KEY_ESC, tle_pkg::KEY_LBRACKET, tle_pkg::KEY_LEFT,
      "z",                               // insert before 'A', tail redraw
      tle_pkg::KEY_ESC, tle_pkg::KEY_LBRACKET, tle_pkg::KEY_RIGHT,
      tle_pkg::KEY_ESC, "Q",             // ESC followed by junk
      tle_pkg::KEY_ESC, tle_pkg::KEY_LBRACKET, "Z",  // unknown CSI final byte
      tle_pkg::KEY_DEL,                  // delete at end of line
      tle_pkg::KEY_ETX,                  // Ctrl-C, event disabled
      "h", tle_pkg::KEY_CR               // commit a one-byte line
    };
    dir_typed = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 1, 1, 1, 1, 1, 0, 1, 0, 0};
    dir_echo = '{
      "\015\012CLI> ", "", "", "", "", " ", "~", "A", "", "", "\010",
      "", "", "", "", "", "", "", "", "", "", "^C\015\012CLI> ", "", ""
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_irq_enable(1'b0);
    for (n = 0; n < DIR_N; n++)
      play_key(dir_key[n], dir_typed[n], dir_echo[n]);

    // event on, full idling, starts with a capacity burst
    set_irq_enable(1'b1);
    run_random(50, 1'b1);

    // event off, back-to-back traffic
    quiet = 1'b1;
    set_irq_enable(1'b0);
    run_random(30, 1'b0);

    quiet = 1'b0;
    set_irq_enable(1'b1);
    run_random(26, 1'b0);

    wait_idle();
    if (mismatches == 0 && pending_words.size() == 0)
      $display("** terminal_line_editor: PASSED **");
    else
      $display("** terminal_line_editor: FAILED **");
    $finish;
  end

endmodule
